### rtl/cls_pkg.sv
// Package: types, codes and the init command table for the character LCD bus sequencer.
package cls_pkg;

	localparam int unsigned SetupW = 10;
	localparam int unsigned WaitW  = 20;
	localparam int unsigned StepW  = 3;
	localparam logic [StepW-1:0] InitLen  = 3'd7;
	localparam logic [StepW-1:0] LastGap  = 3'd2;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_CMD   = 2'd1,
		ACT_DATA  = 2'd2,
		ACT_INIT  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_SETUP = 2'd0,
		CFG_POWER = 2'd1,
		CFG_GAP   = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_POWER      = 4'd1,
		PH_WR_SETUP   = 4'd2,
		PH_WR_HIGH    = 4'd3,
		PH_POLL_SETUP = 4'd4,
		PH_POLL_HIGH  = 4'd5,
		PH_POLL_HOLD  = 4'd6,
		PH_GAP        = 4'd7
	} phase_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] request_byte;
		logic       busy_sample;
	} item_t;

	typedef struct packed {
		logic       reg_select;
		logic       read_not_write;
		logic       enable_pin;
		logic [7:0] bus_out;
		logic       bus_drive;
		logic       ready_res;
	} result_t;

	typedef struct packed {
		logic [SetupW-1:0] setup_ticks;
		logic [WaitW-1:0]  power_on_ticks;
		logic [WaitW-1:0]  init_gap_ticks;
	} cfg_t;

	function automatic logic [7:0] init_byte(input logic [StepW-1:0] step);
		logic [7:0] b;
		unique case (step)
			3'd0, 3'd1, 3'd2: b = 8'h30;
			3'd3:             b = 8'h3F;
			3'd4:             b = 8'h0C;
			3'd5:             b = 8'h06;
			default:          b = 8'h01;
		endcase
		return b;
	endfunction

	// zero delay counts as one tick
	function automatic logic [WaitW-1:0] load_count(input logic [WaitW-1:0] ticks);
		return (ticks == '0) ? WaitW'(1) : ticks;
	endfunction

endpackage

### rtl/cls_seq.sv
// Bus phase sequencer: state registers, next-state logic and pin decode.
module cls_seq
	import cls_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	phase_t             phase_q, phase_d;
	logic [WaitW-1:0]   wait_q, wait_d;
	logic [StepW-1:0]   step_q, step_d;
	logic [7:0]         byte_q, byte_d;
	logic               sel_q, sel_d;
	logic               init_q, init_d;
	logic               busy_q, busy_d;
	logic [WaitW-1:0]   setup_cnt;
	logic [StepW-1:0]   step_inc;

	assign setup_cnt = load_count(WaitW'(cfg.setup_ticks));
	assign step_inc  = step_q + StepW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= '0;
			step_q  <= '0;
			byte_q  <= '0;
			sel_q   <= 1'b0;
			init_q  <= 1'b0;
			busy_q  <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			step_q  <= step_d;
			byte_q  <= byte_d;
			sel_q   <= sel_d;
			init_q  <= init_d;
			busy_q  <= busy_d;
		end
	end

	always_comb begin
		res = '{reg_select: 1'b0, read_not_write: 1'b0, enable_pin: 1'b0,
			bus_out: byte_q, bus_drive: 1'b1, ready_res: 1'b0};
		unique case (phase_q)
			PH_IDLE:       res.ready_res = 1'b1;
			PH_WR_SETUP:   res.reg_select = sel_q;
			PH_WR_HIGH: begin
				res.reg_select = sel_q;
				res.enable_pin = 1'b1;
			end
			PH_POLL_SETUP: begin
				res.read_not_write = 1'b1;
				res.bus_drive      = 1'b0;
				res.bus_out        = '0;
			end
			PH_POLL_HIGH, PH_POLL_HOLD: begin
				res.read_not_write = 1'b1;
				res.enable_pin     = 1'b1;
				res.bus_drive      = 1'b0;
				res.bus_out        = '0;
			end
			default: ;
		endcase

		phase_d = phase_q;
		wait_d  = wait_q;
		step_d  = step_q;
		byte_d  = byte_q;
		sel_d   = sel_q;
		init_d  = init_q;
		busy_d  = busy_q;

		if (phase_q == PH_IDLE) begin
			unique case (action_t'(item.action))
				ACT_CMD, ACT_DATA: begin
					byte_d  = item.request_byte;
					sel_d   = (action_t'(item.action) == ACT_DATA);
					phase_d = PH_WR_SETUP;
					wait_d  = setup_cnt;
				end
				ACT_INIT: begin
					init_d  = 1'b1;
					step_d  = '0;
					phase_d = PH_POWER;
					wait_d  = load_count(cfg.power_on_ticks);
				end
				default: ;
			endcase
		end else if (wait_q > WaitW'(1)) begin
			wait_d = wait_q - WaitW'(1);
		end else begin
			unique case (phase_q)
				PH_POWER: begin
					step_d  = '0;
					byte_d  = init_byte('0);
					sel_d   = 1'b0;
					phase_d = PH_WR_SETUP;
					wait_d  = setup_cnt;
				end
				PH_WR_SETUP: begin
					phase_d = PH_WR_HIGH;
					wait_d  = setup_cnt;
				end
				PH_WR_HIGH, PH_POLL_HOLD: begin
					wait_d  = setup_cnt;
					phase_d = PH_POLL_SETUP;
					if (phase_q == PH_POLL_HOLD && !busy_q) begin
						if (init_q && step_q <= LastGap) begin
							phase_d = PH_GAP;
							wait_d  = load_count(cfg.init_gap_ticks);
						end else if (init_q) begin
							if (step_inc == InitLen) begin
								init_d  = 1'b0;
								step_d  = '0;
								phase_d = PH_IDLE;
								wait_d  = '0;
							end else begin
								step_d  = step_inc;
								byte_d  = init_byte(step_inc);
								sel_d   = 1'b0;
								phase_d = PH_WR_SETUP;
							end
						end else begin
							phase_d = PH_IDLE;
							wait_d  = '0;
						end
					end
				end
				PH_POLL_SETUP: begin
					phase_d = PH_POLL_HIGH;
					wait_d  = setup_cnt;
				end
				PH_POLL_HIGH: begin
					busy_d  = item.busy_sample;
					phase_d = PH_POLL_HOLD;
					wait_d  = setup_cnt;
				end
				PH_GAP: begin
					if (step_inc == InitLen) begin
						init_d  = 1'b0;
						step_d  = '0;
						phase_d = PH_IDLE;
						wait_d  = '0;
					end else begin
						step_d  = step_inc;
						byte_d  = init_byte(step_inc);
						sel_d   = 1'b0;
						phase_d = PH_WR_SETUP;
						wait_d  = setup_cnt;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					wait_d  = '0;
				end
			endcase
		end
	end

endmodule

### rtl/char_lcd_bus_sequencer_top.sv
// Top level of the character LCD bus sequencer: ports, config registers, result register.
//
//  channel | signals                       | direction
//  item    | item_valid, item_stall, item  | request in, one per tick
//  res     | res_valid, res_stall, res     | pin levels out, one per request
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes in
//
// One request per cycle while item_stall is low; each yields one result, registered in
// the result register and shown in the cycle after the request is taken.
// Reset clears the sequencer state and the result valid flag and loads the default register values; res_q is not reset.
// item_stall is high only while a result waits and res_stall is high.
module char_lcd_bus_sequencer_top
	import cls_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  item_t         item,
	output logic          res_valid,
	input  logic          res_stall,
	output result_t       res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [WaitW-1:0] cfg_data
);

	cfg_t    cfg_q;
	result_t res_d;
	result_t res_q;
	logic    valid_q;
	logic    adv;

	assign cfg_ready  = 1'b1;
	assign item_stall = valid_q & res_stall;
	assign adv        = item_valid & ~item_stall;
	assign res_valid  = valid_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setup_ticks    <= SetupW'(10);
			cfg_q.power_on_ticks <= WaitW'(40000);
			cfg_q.init_gap_ticks <= WaitW'(10000);
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SETUP: cfg_q.setup_ticks    <= cfg_data[SetupW-1:0];
				CFG_POWER: cfg_q.power_on_ticks <= cfg_data;
				CFG_GAP:   cfg_q.init_gap_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	cls_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

endmodule

### tb/testbench.sv
// Testbench for char_lcd_bus_sequencer_top: random and directed pin-sequence checks.
`timescale 1ns / 1ps

module testbench
	import cls_pkg::*;
();

	localparam int unsigned WATCHDOG = 2000;
	localparam logic [55:0] BOOT_SEQ = 56'h30_30_30_3F_0C_06_01;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	item_t            item = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	result_t          res;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = '0;
	logic [WaitW-1:0] cfg_data = '0;

	char_lcd_bus_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted sequencer state and registers
	phase_t      lcd_phase = PH_IDLE;
	logic [19:0] lcd_wait = '0;
	logic [3:0]  boot_step = '0;
	logic [7:0]  latch_byte = '0;
	logic        latch_rs = 1'b0;
	logic        boot_active = 1'b0;
	logic        busy_seen = 1'b0;
	logic [9:0]  t_setup = 10'd10;
	logic [19:0] t_power = 20'd40000;
	logic [19:0] t_gap = 20'd10000;

	item_t       tick_queue[$];
	result_t     pin_expect[$];
	int unsigned req_taken = 0;
	int unsigned errors = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit          item_taken = 1'b0;
	bit          jitter_on = 1'b1;
	bit          hold_req = 1'b0;
	logic        drv_valid;
	item_t       drv_item;
	logic        drv_stall;
	result_t     want;

	function automatic logic [7:0] boot_cmd(input logic [3:0] step);
		return BOOT_SEQ[(6 - int'(step)) * 8 +: 8];
	endfunction

	function automatic void arm(input phase_t ph, input logic [19:0] ticks);
		lcd_phase = ph;
		lcd_wait = (ticks == '0) ? 20'd1 : ticks;
	endfunction

	function automatic void begin_write(input logic [7:0] b, input logic rs);
		latch_byte = b;
		latch_rs = rs;
		arm(PH_WR_SETUP, 20'(t_setup));
	endfunction

	function automatic void boot_next();
		boot_step = boot_step + 4'd1;
		if (boot_step >= 4'd7) begin
			boot_active = 1'b0;
			boot_step = '0;
			arm(PH_IDLE, '0);
		end else begin
			begin_write(boot_cmd(boot_step), 1'b0);
		end
	endfunction

	// pins for this tick come from the state before it
	function automatic result_t lcd_step(input item_t it);
		result_t r;
		r = '0;
		r.bus_drive = 1'b1;
		r.bus_out = latch_byte;
		case (lcd_phase)
			PH_IDLE: r.ready_res = 1'b1;
			PH_WR_SETUP: r.reg_select = latch_rs;
			PH_WR_HIGH: begin
				r.reg_select = latch_rs;
				r.enable_pin = 1'b1;
			end
			PH_POLL_SETUP: begin
				r.read_not_write = 1'b1;
				r.bus_drive = 1'b0;
				r.bus_out = '0;
			end
			PH_POLL_HIGH, PH_POLL_HOLD: begin
				r.read_not_write = 1'b1;
				r.enable_pin = 1'b1;
				r.bus_drive = 1'b0;
				r.bus_out = '0;
			end
			default: ;
		endcase
		if (lcd_phase == PH_IDLE) begin
			if (it.action == ACT_CMD || it.action == ACT_DATA) begin
				begin_write(it.request_byte, it.action == ACT_DATA);
			end else if (it.action == ACT_INIT) begin
				boot_active = 1'b1;
				boot_step = '0;
				arm(PH_POWER, t_power);
			end
			if (it.action != ACT_TICK)
				req_taken++;
		end else if (lcd_wait > 20'd1) begin
			lcd_wait = lcd_wait - 20'd1;
		end else begin
			case (lcd_phase)
				PH_POWER: begin
					boot_step = '0;
					begin_write(boot_cmd(4'd0), 1'b0);
				end
				PH_WR_SETUP: arm(PH_WR_HIGH, 20'(t_setup));
				PH_WR_HIGH: arm(PH_POLL_SETUP, 20'(t_setup));
				PH_POLL_SETUP: arm(PH_POLL_HIGH, 20'(t_setup));
				PH_POLL_HIGH: begin
					busy_seen = it.busy_sample;
					arm(PH_POLL_HOLD, 20'(t_setup));
				end
				PH_POLL_HOLD: begin
					if (busy_seen)
						arm(PH_POLL_SETUP, 20'(t_setup));
					else if (!boot_active)
						arm(PH_IDLE, '0);
					else if (boot_step <= 4'd2)
						arm(PH_GAP, t_gap);
					else
						boot_next();
				end
				PH_GAP: boot_next();
				default: arm(PH_IDLE, '0);
			endcase
		end
		return r;
	endfunction

	function automatic void check_pin(input string pin, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t: %s expected %h actual %h", $time, pin, exp_v, got_v);
		end
	endfunction

	task automatic queue_item(input action_t a, input logic [7:0] b, input logic bsy);
		item_t it;
		it.action = a;
		it.request_byte = b;
		it.busy_sample = bsy;
		tick_queue.push_back(it);
	endtask

	task automatic queue_random(input bit with_init);
		int unsigned pick;
		action_t a;
		pick = $urandom_range(0, 19);
		if (pick < 2)
			a = ACT_TICK;
		else if (pick < 10)
			a = ACT_CMD;
		else if (pick < 19)
			a = ACT_DATA;
		else
			a = with_init ? ACT_INIT : ACT_CMD;
		queue_item(a, 8'($urandom), $urandom_range(0, 3) == 0);
	endtask

	task automatic wait_drained();
		while (tick_queue.size() != 0 || item_valid || pin_expect.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_to_idle();
		wait_drained();
		while (lcd_phase != PH_IDLE) begin
			repeat (32)
				queue_item(ACT_TICK, 8'($urandom), $urandom_range(0, 7) == 0);
			wait_drained();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [19:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_SETUP: t_setup = val[9:0];
			CFG_POWER: t_power = val;
			default:   t_gap = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	// request side: record acceptance and predict
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			pin_expect.push_back(lcd_step(item));
			item_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_taken)) begin
			item_taken = 1'b0;
			drv_valid = 1'b0;
			drv_item = item;
			if (send_gap != 0) begin
				send_gap--;
			end else if (jitter_on && $urandom_range(0, 11) == 0) begin
				send_gap = $urandom_range(0, 15);
			end else if (tick_queue.size() != 0) begin
				drv_item = tick_queue.pop_front();
				drv_valid = 1'b1;
			end
			item_valid <= drv_valid;
			item <= drv_item;
		end
	end

	// result side
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_left = 64;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				drv_stall = 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				drv_stall = 1'b1;
			end else if (jitter_on && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(0, 15);
				drv_stall = 1'b1;
			end else begin
				drv_stall = 1'b0;
			end
			res_stall <= drv_stall;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pin_expect.size() == 0) begin
				errors++;
				$display("%0t: unexpected result expected none actual %h", $time, res);
			end else begin
				want = pin_expect.pop_front();
				check_pin("reg_select", 8'(want.reg_select), 8'(res.reg_select));
				check_pin("read_not_write", 8'(want.read_not_write), 8'(res.read_not_write));
				check_pin("enable_pin", 8'(want.enable_pin), 8'(res.enable_pin));
				check_pin("bus_out", want.bus_out, res.bus_out);
				check_pin("bus_drive", 8'(want.bus_drive), 8'(res.bus_drive));
				check_pin("ready_res", 8'(want.ready_res), 8'(res.ready_res));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("[char_lcd_bus_sequencer_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int unsigned goal;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: tick while idle, writes, request while busy, long busy polling
		queue_item(ACT_TICK, 8'hA5, 1'b1);
		queue_item(ACT_CMD, 8'h00, 1'b0);
		repeat (40) queue_item(ACT_TICK, 8'h00, 1'b1);
		queue_item(ACT_DATA, 8'hFF, 1'b1);
		repeat (40) queue_item(ACT_TICK, 8'hFF, 1'b1);
		run_to_idle();
		queue_item(ACT_DATA, 8'hFF, 1'b0);
		run_to_idle();
		queue_item(ACT_CMD, 8'hFF, 1'b1);
		run_to_idle();

		// zero delays count as one tick
		write_reg(CFG_SETUP, 20'd0);
		write_reg(CFG_POWER, 20'd0);
		write_reg(CFG_GAP, 20'd0);
		queue_item(ACT_INIT, 8'hFF, 1'b0);
		queue_item(ACT_CMD, 8'h12, 1'b0);
		run_to_idle();
		queue_item(ACT_DATA, 8'h00, 1'b1);
		run_to_idle();
		queue_item(ACT_INIT, 8'h00, 1'b1);
		run_to_idle();

		// setup written above its width, shortest init waits
		write_reg(CFG_SETUP, 20'hFFC03);
		write_reg(CFG_POWER, 20'd1);
		write_reg(CFG_GAP, 20'd1);
		queue_item(ACT_CMD, 8'hAA, 1'b0);
		run_to_idle();
		queue_item(ACT_INIT, 8'h55, 1'b0);
		run_to_idle();

		// longest init waits written, plain writes only
		write_reg(CFG_SETUP, 20'd1);
		write_reg(CFG_POWER, 20'hFFFFF);
		write_reg(CFG_GAP, 20'hFFFFF);
		queue_item(ACT_DATA, 8'h5A, 1'b1);
		queue_item(ACT_CMD, 8'hA5, 1'b0);
		run_to_idle();
		goal = req_taken + 30;
		while (req_taken < goal) begin
			while (tick_queue.size() > 8)
				@(posedge clk);
			queue_random(1'b0);
		end
		run_to_idle();

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(CFG_SETUP, (ph == 0) ? 20'd0 : 20'($urandom_range(1, 4)));
			write_reg(CFG_POWER, 20'($urandom_range(0, 64)));
			write_reg(CFG_GAP, 20'($urandom_range(0, 64)));
			jitter_on = (ph != 1) && (ph != 4);
			if (ph == 2)
				hold_req = 1'b1;
			goal = req_taken + 6;
			while (req_taken < goal) begin
				while (tick_queue.size() > 8)
					@(posedge clk);
				queue_random(1'b1);
			end
			run_to_idle();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("[char_lcd_bus_sequencer_top] OK");
		else
			$display("[char_lcd_bus_sequencer_top] ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/cls_pkg.sv
rtl/cls_seq.sv
rtl/char_lcd_bus_sequencer_top.sv
tb/testbench.sv
